// ===== rtl/wlsp_pkg.sv =====
`timescale 1ns / 1ps

package wlsp_pkg;

    localparam int SECTOR_COUNT_DEF = 8;
    localparam int IDX_W            = 3;
    localparam int IDX_SPAN         = 1 << IDX_W;
    localparam int WORD_W           = 32;
    localparam int IN_FLAGS_W       = 3;
    localparam int IN_DATA_W        = 3 * WORD_W;
    localparam int OUT_DATA_W       = 8;

    localparam logic [WORD_W-1:0] ERASE_INIT     = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] SERIAL_HALF    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WRAP_SEQ_MIN   = 32'hFFFF_FFF0;
    localparam logic [WORD_W-1:0] WRAP_REF_LIMIT = 32'd10;
    localparam logic [WORD_W-1:0] PROTECT_SPAN   = 32'd4;

    typedef enum logic [1:0] {
        REASON_CORRUPT    = 2'd0,
        REASON_LEAST_WORN = 2'd1,
        REASON_FALLBACK   = 2'd2
    } t_reason;

    typedef struct packed {
        logic             excluded;
        logic             read_failed;
        logic             header_valid;
    } t_flags;

endpackage

// ===== rtl/wear_level_sector_picker.sv =====
`timescale 1ns / 1ps

// A last request is held in the s1 registers, then its pick is registered to o_m_axis_tvalid.
// Throughput: one request per cycle unless stalled; the minimum compare is in the pass loop.
// A pick waiting on the output stalls intake only when another last request is due.
// Reset (i_rst_n low, synchronous): pass state, position and both valid flags clear.
// No clearing pass; the block takes requests as soon as reset is released.
module wear_level_sector_picker #(
    parameter int SECTOR_COUNT = wlsp_pkg::SECTOR_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] sequence_number, [63:32] erase_total, [95:64] reference_sequence
    input  logic [wlsp_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [0] header_valid, [1] read_failed, [2] excluded
    input  logic [wlsp_pkg::IN_FLAGS_W-1:0]   i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [2:0] chosen_sector, [7:3] zero
    output logic [wlsp_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // [1:0] pick_reason
    output wlsp_pkg::t_reason                 o_m_axis_tuser
);
    import wlsp_pkg::*;

    localparam int              WRAP     = (SECTOR_COUNT < IDX_SPAN) ? SECTOR_COUNT : IDX_SPAN;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(WRAP - 1);

    logic              r_s1_valid;
    t_flags            r_s1_flags;
    logic [WORD_W-1:0] r_s1_seq;
    logic [WORD_W-1:0] r_s1_erase;
    logic [WORD_W-1:0] r_s1_ref;
    logic              r_s1_last;

    logic [IDX_W-1:0]  r_position,     n_position;
    logic              r_best_found,   n_best_found;
    logic [IDX_W-1:0]  r_best_index,   n_best_index;
    logic [WORD_W-1:0] r_least_erase,  n_least_erase;
    logic              r_corrupt_found, n_corrupt_found;
    logic [IDX_W-1:0]  r_corrupt_index, n_corrupt_index;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_sector,   n_out_sector;
    t_reason           r_out_reason,   n_out_reason;

    logic              w_advance;
    logic              w_in_take;
    logic [WORD_W-1:0] w_diff_sr;
    logic [WORD_W-1:0] w_diff_rs;
    logic              w_newer;
    logic              w_protected;

    assign w_advance       = r_s1_valid && (!r_s1_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - IDX_W){1'b0}}, r_out_sector};
    assign o_m_axis_tuser  = r_out_reason;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
        if (w_in_take) begin
            r_s1_flags <= t_flags'(i_s_axis_tuser);
            r_s1_seq   <= i_s_axis_tdata[WORD_W-1:0];
            r_s1_erase <= i_s_axis_tdata[2*WORD_W-1:WORD_W];
            r_s1_ref   <= i_s_axis_tdata[3*WORD_W-1:2*WORD_W];
            r_s1_last  <= i_s_axis_tlast;
        end
    end

    // serial comparison with the wrap guard
    always_comb begin
        w_diff_sr = r_s1_seq - r_s1_ref;
        w_diff_rs = r_s1_ref - r_s1_seq;
        if (r_s1_seq == r_s1_ref) begin
            w_newer = 1'b0;
        end else if (r_s1_seq > r_s1_ref) begin
            w_newer = (w_diff_sr <= SERIAL_HALF);
        end else begin
            w_newer = (w_diff_rs > SERIAL_HALF);
        end
        w_protected = !w_newer
                      && ((r_s1_ref >= r_s1_seq)
                          || ((r_s1_seq > WRAP_SEQ_MIN) && (r_s1_ref < WRAP_REF_LIMIT)))
                      && (w_diff_rs < PROTECT_SPAN);
    end

    always_comb begin
        n_best_found    = r_best_found;
        n_best_index    = r_best_index;
        n_least_erase   = r_least_erase;
        n_corrupt_found = r_corrupt_found;
        n_corrupt_index = r_corrupt_index;
        n_position      = (r_position == LAST_POS) ? '0 : r_position + 1'b1;

        if (!r_corrupt_found && !r_s1_flags.excluded && !r_s1_flags.read_failed) begin
            if (!r_s1_flags.header_valid) begin
                n_corrupt_found = 1'b1;
                n_corrupt_index = r_position;
            end else if (!w_protected && (r_s1_erase < r_least_erase)) begin
                n_least_erase = r_s1_erase;
                n_best_index  = r_position;
                n_best_found  = 1'b1;
            end
        end

        if (n_corrupt_found) begin
            n_out_sector = n_corrupt_index;
            n_out_reason = REASON_CORRUPT;
        end else if (n_best_found) begin
            n_out_sector = n_best_index;
            n_out_reason = REASON_LEAST_WORN;
        end else begin
            n_out_sector = '0;
            n_out_reason = REASON_FALLBACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position      <= '0;
            r_best_found    <= 1'b0;
            r_best_index    <= '0;
            r_least_erase   <= ERASE_INIT;
            r_corrupt_found <= 1'b0;
            r_corrupt_index <= '0;
        end else if (w_advance) begin
            if (r_s1_last) begin
                r_position      <= '0;
                r_best_found    <= 1'b0;
                r_best_index    <= '0;
                r_least_erase   <= ERASE_INIT;
                r_corrupt_found <= 1'b0;
                r_corrupt_index <= '0;
            end else begin
                r_position      <= n_position;
                r_best_found    <= n_best_found;
                r_best_index    <= n_best_index;
                r_least_erase   <= n_least_erase;
                r_corrupt_found <= n_corrupt_found;
                r_corrupt_index <= n_corrupt_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && r_s1_last) begin
            r_out_sector <= n_out_sector;
            r_out_reason <= n_out_reason;
        end
    end

`ifndef NO_ASSERTIONS
    a_fallback_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_reason == REASON_FALLBACK) |-> (r_out_sector == '0))
        else $error("fallback pick with nonzero sector");

    a_pass_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_s1_last |=> (r_position == '0) && !r_corrupt_found && !r_best_found
                                    && (r_least_erase == ERASE_INIT))
        else $error("pass state not cleared after pick");

    a_corrupt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_corrupt_found && !(w_advance && r_s1_last) |=> r_corrupt_found
                                                         && $stable(r_corrupt_index))
        else $error("corrupt pick lost within a pass");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !(w_advance && r_s1_last))
        else $error("pick overwritten before delivery");

    a_best_below_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_found |-> (r_least_erase != ERASE_INIT))
        else $error("best candidate holds an all-ones erase count");
`endif

endmodule
